// ===== rtl/cms_pkg.sv =====
// Shared types and constants of the count-min sketch accumulator.
package cms_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_BUCKETS = 256;
    localparam int COUNTER_W   = 48;
    localparam int VAL_W       = 31;
    localparam int ROW_W       = 7;
    localparam int NCELLS      = 31;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_START  = 2'd3
    } op_t;

    localparam logic CFG_NUM_ROWS    = 1'b0;
    localparam logic CFG_NUM_BUCKETS = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  row_index;
        logic [30:0] row_prime;
        logic [30:0] row_step;
        logic [30:0] row_offset;
        logic signed [31:0] sample_value;
        logic [10:0] counter_index;
    } in_t;

    typedef struct packed {
        logic signed [47:0] counter_value;
        logic               counter_saturated;
    } out_t;

    typedef enum logic [1:0] {
        K_STEP   = 2'd0,
        K_OFFSET = 2'd1,
        K_BUCKET = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ROW_W-1:0]  row;
    } tag_t;

    // One request moving down the remainder chain.
    typedef struct packed {
        logic             valid;
        tag_t             tag;
        logic [VAL_W-1:0] divisor;
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] dividend;
    } cell_t;

endpackage

// ===== rtl/cms_mod_cell.sv =====
// One restoring remainder step: bring in one dividend bit, subtract if it fits.
module cms_mod_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  cms_pkg::cell_t  cell_in,
    output cms_pkg::cell_t  cell_out
);
    logic [cms_pkg::VAL_W:0] trial;
    logic [cms_pkg::VAL_W:0] dvs;
    logic [cms_pkg::VAL_W:0] diff;
    cms_pkg::cell_t          cell_reg;
    cms_pkg::cell_t          cell_next;

    always_comb begin
        trial = {cell_in.rem, cell_in.dividend[cms_pkg::VAL_W-1]};
        dvs   = {1'b0, cell_in.divisor};
        diff  = trial - dvs;
        cell_next          = cell_in;
        cell_next.rem      = (trial >= dvs) ? diff[cms_pkg::VAL_W-1:0]
                                            : trial[cms_pkg::VAL_W-1:0];
        cell_next.dividend = {cell_in.dividend[cms_pkg::VAL_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
        cell_reg.tag      <= cell_next.tag;
        cell_reg.divisor  <= cell_next.divisor;
        cell_reg.rem      <= cell_next.rem;
        cell_reg.dividend <= cell_next.dividend;
    end

    assign cell_out = cell_reg;
endmodule

// ===== rtl/cms_mod_chain.sv =====
// Row of remainder cells; one request enters per cycle, remainder leaves at the end.
module cms_mod_chain (
    input  logic            aclk,
    input  logic            aresetn,
    input  cms_pkg::cell_t  chain_in,
    output cms_pkg::cell_t  chain_out,
    output logic            busy
);
    cms_pkg::cell_t st [0:cms_pkg::NCELLS];

    assign st[0] = chain_in;

    for (genvar k = 0; k < cms_pkg::NCELLS; k++) begin : g_cell
        cms_mod_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (st[k]),
            .cell_out (st[k+1])
        );
    end

    always_comb begin
        busy = 1'b0;
        for (int k = 1; k <= cms_pkg::NCELLS; k++) begin
            busy = busy | st[k].valid;
        end
    end

    assign chain_out = st[cms_pkg::NCELLS];
endmodule

// ===== rtl/count_min_sketch_accumulate_core.sv =====
// Top level of the count-min sketch accumulator.
//
//  channel | ports                     | direction | carries
//  s_      | s_valid s_ready s_data    | in        | operation request (in_t)
//  m_      | m_valid m_ready m_data    | out       | counter read result (out_t)
//  cfg_    | cfg_wr_en cfg_index cfg_wr_data | in    | num_rows, num_buckets
//
// Load: step and offset are reduced mod prime in the 31-cell chain.
// Sample: one row per cycle into the chain, then read-modify-write of the counter
// memory. A zero sample advances the residues but writes no counter.
// Read: S_READ waits while an unaccepted result is held, then S_RDWAIT loads the result.
// Start and reset: clearing pass over all MAX_ROWS*MAX_BUCKETS counters, no request taken.
// Reset is synchronous, active low; the result register holds while m_ready is low.
module count_min_sketch_accumulate_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cms_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cms_pkg::out_t  m_data,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [8:0]     cfg_wr_data
);
    localparam int MAX_ROWS    = cms_pkg::MAX_ROWS;
    localparam int MAX_BUCKETS = cms_pkg::MAX_BUCKETS;
    localparam int SD  = MAX_ROWS * MAX_BUCKETS;
    localparam int AW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CW  = cms_pkg::COUNTER_W;
    localparam int VW  = cms_pkg::VAL_W;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_SAMPLE = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RDWAIT = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [RCW-1:0]  iss_cnt_reg, iss_cnt_next;
    cms_pkg::in_t    item_reg;
    logic [3:0]      num_rows_reg;
    logic [8:0]      num_buckets_reg;

    logic [VW-1:0]   prime_reg   [MAX_ROWS];
    logic [VW-1:0]   step_reg    [MAX_ROWS];
    logic [VW-1:0]   offset_reg  [MAX_ROWS];
    logic [VW-1:0]   residue_reg [MAX_ROWS];

    logic [CW:0]     mem [SD];
    logic [CW:0]     mem_q;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_raddr;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_waddr;
    logic [CW:0]     mem_wdata;

    cms_pkg::cell_t  chain_in, chain_out;
    logic            chain_busy;

    logic            a1_v_reg;
    logic [AW-1:0]   a1_idx_reg;
    logic            a2_v_reg;
    logic [AW-1:0]   a2_idx_reg;
    logic            rd_oob_reg;
    logic            m_valid_reg;
    cms_pkg::out_t   m_data_reg;

    logic [RCW-1:0]  rows_eff;
    logic [VW-1:0]   b_eff;
    logic [VW-1:0]   load_prime;
    logic [RW-1:0]   iss_row;
    logic [VW:0]     res_sum;
    logic [VW:0]     res_sub;
    logic [VW-1:0]   res_new;
    logic            s_fire;
    logic [31:0]     a1_idx_full;

    // Effective configuration.
    always_comb begin
        if (32'(num_rows_reg) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
        else                              rows_eff = RCW'(num_rows_reg);
        if (num_buckets_reg == 9'd0)              b_eff = VW'(1);
        else if (32'(num_buckets_reg) > MAX_BUCKETS) b_eff = VW'(MAX_BUCKETS);
        else                                      b_eff = VW'(num_buckets_reg);
        load_prime = (s_data.row_prime < VW'(2)) ? VW'(2) : s_data.row_prime;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign iss_row = iss_cnt_reg[RW-1:0];

    // Residue advance: both terms are below the prime, so one subtract reduces.
    always_comb begin
        res_sum = {1'b0, residue_reg[iss_row]} + {1'b0, step_reg[iss_row]};
        res_sub = res_sum - {1'b0, prime_reg[iss_row]};
        res_new = (res_sum >= {1'b0, prime_reg[iss_row]}) ? res_sub[VW-1:0]
                                                           : res_sum[VW-1:0];
    end

    // Chain feed.
    always_comb begin
        chain_in          = '0;
        chain_in.tag.kind = cms_pkg::K_BUCKET;
        if (state_reg == S_LOAD && iss_cnt_reg < RCW'(2)) begin
            chain_in.valid    = 1'b1;
            chain_in.tag.kind = (iss_cnt_reg == '0) ? cms_pkg::K_STEP : cms_pkg::K_OFFSET;
            chain_in.tag.row  = cms_pkg::ROW_W'(item_reg.row_index);
            chain_in.divisor  = prime_reg[item_reg.row_index[RW-1:0]];
            chain_in.dividend = (iss_cnt_reg == '0) ? item_reg.row_step : item_reg.row_offset;
        end else if (state_reg == S_SAMPLE && iss_cnt_reg < rows_eff) begin
            chain_in.valid    = (item_reg.sample_value != 32'sd0);
            chain_in.tag.row  = cms_pkg::ROW_W'(iss_row);
            chain_in.divisor  = b_eff;
            chain_in.dividend = res_new;
        end
    end

    cms_mod_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chain_in  (chain_in),
        .chain_out (chain_out),
        .busy      (chain_busy)
    );

    assign a1_idx_full = 32'(chain_out.tag.row) * 32'(b_eff) + 32'(chain_out.rem);

    // Control.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        iss_cnt_next = iss_cnt_reg;
        mem_rd_en    = 1'b0;
        mem_raddr    = a1_idx_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == SD - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    iss_cnt_next = '0;
                    clr_cnt_next = '0;
                    unique case (cms_pkg::op_t'(s_data.operation))
                        cms_pkg::OP_LOAD: begin
                            state_next = (32'(s_data.row_index) < MAX_ROWS) ? S_LOAD : S_IDLE;
                        end
                        cms_pkg::OP_SAMPLE: state_next = S_SAMPLE;
                        cms_pkg::OP_READ:   state_next = S_READ;
                        cms_pkg::OP_START:  state_next = S_CLEAR;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                iss_cnt_next = iss_cnt_reg + RCW'(1);
                if (iss_cnt_reg == RCW'(1)) state_next = S_DRAIN;
            end
            S_SAMPLE: begin
                if (iss_cnt_reg >= rows_eff) begin
                    state_next = S_DRAIN;
                end else begin
                    iss_cnt_next = iss_cnt_reg + RCW'(1);
                end
            end
            S_DRAIN: begin
                mem_rd_en = a1_v_reg;
                if (!chain_busy && !a1_v_reg && !a2_v_reg) state_next = S_IDLE;
            end
            S_READ: begin
                mem_raddr = item_reg.counter_index[AW-1:0];
                if (!m_valid_reg || m_ready) begin
                    mem_rd_en  = 1'b1;
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        if (state_reg == S_SAMPLE) mem_rd_en = a1_v_reg;
    end

    // Saturating accumulate.
    always_comb begin
        logic signed [CW:0] c_ext;
        logic signed [CW:0] s_ext;
        logic signed [CW:0] sum;
        logic               sat;
        logic [CW-1:0]      c_new;
        c_ext = {mem_q[CW-1], mem_q[CW-1:0]};
        s_ext = (CW+1)'(item_reg.sample_value);
        sum   = c_ext + s_ext;
        sat   = (sum[CW] != sum[CW-1]);
        if (!sat)         c_new = sum[CW-1:0];
        else if (!sum[CW]) c_new = {1'b0, {(CW-1){1'b1}}};
        else               c_new = {1'b1, {(CW-1){1'b0}}};
        mem_wr_en = 1'b0;
        mem_waddr = a2_idx_reg;
        mem_wdata = {mem_q[CW] | sat, c_new};
        if (state_reg == S_CLEAR) begin
            mem_wr_en = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (a2_v_reg) begin
            mem_wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) mem[mem_waddr] <= mem_wdata;
        if (mem_rd_en) mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            iss_cnt_reg     <= '0;
            num_rows_reg    <= 4'd1;
            num_buckets_reg <= 9'd256;
            a1_v_reg        <= 1'b0;
            a2_v_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int r = 0; r < MAX_ROWS; r++) begin
                prime_reg[r]   <= VW'(2);
                step_reg[r]    <= '0;
                offset_reg[r]  <= '0;
                residue_reg[r] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            iss_cnt_reg <= iss_cnt_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    cms_pkg::CFG_NUM_ROWS:    num_rows_reg    <= cfg_wr_data[3:0];
                    cms_pkg::CFG_NUM_BUCKETS: num_buckets_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_fire && cms_pkg::op_t'(s_data.operation) == cms_pkg::OP_LOAD
                    && 32'(s_data.row_index) < MAX_ROWS) begin
                prime_reg[s_data.row_index[RW-1:0]] <= load_prime;
            end
            // Reload residues from offsets during the first rows of a clear pass.
            if (state_reg == S_CLEAR && 32'(clr_cnt_reg) < MAX_ROWS) begin
                residue_reg[clr_cnt_reg[RW-1:0]] <= offset_reg[clr_cnt_reg[RW-1:0]];
            end
            if (state_reg == S_SAMPLE && iss_cnt_reg < rows_eff) begin
                residue_reg[iss_row] <= res_new;
            end
            if (chain_out.valid && chain_out.tag.kind == cms_pkg::K_STEP) begin
                step_reg[chain_out.tag.row[RW-1:0]] <= chain_out.rem;
            end
            if (chain_out.valid && chain_out.tag.kind == cms_pkg::K_OFFSET) begin
                offset_reg[chain_out.tag.row[RW-1:0]]  <= chain_out.rem;
                residue_reg[chain_out.tag.row[RW-1:0]] <= chain_out.rem;
            end
            a1_v_reg <= chain_out.valid && chain_out.tag.kind == cms_pkg::K_BUCKET;
            a2_v_reg <= a1_v_reg;
            if (state_reg == S_RDWAIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) item_reg <= s_data;
        a1_idx_reg <= a1_idx_full[AW-1:0];
        a2_idx_reg <= a1_idx_reg;
        if (state_reg == S_READ) begin
            rd_oob_reg <= (32'(item_reg.counter_index) >= SD);
        end
        if (state_reg == S_RDWAIT) begin
            m_data_reg.counter_value     <= rd_oob_reg ? '0 : mem_q[CW-1:0];
            m_data_reg.counter_saturated <= rd_oob_reg ? 1'b0 : mem_q[CW];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// ===== verif/cms_checker.sv =====
// Scoreboard for the count-min sketch core: mirrors the sketch and checks each counter read.
`timescale 1ns / 100ps
module cms_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  cms_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  cms_pkg::out_t  m_data,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [8:0]     cfg_wr_data,
    output int             fail_count,
    output int             pending,
    output int             reads_checked,
    output int             samples_seen
);

    localparam int ROWS    = cms_pkg::MAX_ROWS;
    localparam int BUCKETS = cms_pkg::MAX_BUCKETS;
    localparam int DEPTH   = ROWS * BUCKETS;
    localparam longint CNT_HI = (longint'(1) <<< 47) - 1;
    localparam longint CNT_LO = -CNT_HI - 1;

    logic [3:0]  rows_reg;
    logic [8:0]  buckets_reg;
    logic [30:0] prime_tab  [ROWS];
    logic [30:0] step_tab   [ROWS];
    logic [30:0] offset_tab [ROWS];
    logic [30:0] residue_tab[ROWS];
    logic signed [47:0] sketch [DEPTH];
    bit          sat_flag [DEPTH];
    cms_pkg::out_t read_q[$];

    function automatic void clear_sketch();
        for (int i = 0; i < DEPTH; i++) begin
            sketch[i]   = '0;
            sat_flag[i] = 1'b0;
        end
    endfunction

    function automatic void reset_sketch();
        rows_reg    = 4'd1;
        buckets_reg = 9'd256;
        for (int r = 0; r < ROWS; r++) begin
            prime_tab[r]   = 31'd2;
            step_tab[r]    = '0;
            offset_tab[r]  = '0;
            residue_tab[r] = '0;
        end
        clear_sketch();
        read_q.delete();
    endfunction

    function automatic void add_to_counter(int idx, longint s);
        longint c;
        c = sketch[idx];
        if (c + s > CNT_HI) begin
            c = CNT_HI;
            sat_flag[idx] = 1'b1;
        end else if (c + s < CNT_LO) begin
            c = CNT_LO;
            sat_flag[idx] = 1'b1;
        end else begin
            c = c + s;
        end
        sketch[idx] = c[47:0];
    endfunction

    // Update the mirror for one request; queue the result of a read.
    function automatic void apply_request(cms_pkg::in_t req);
        int      nrows;
        int      nb;
        longint  s;
        longint unsigned res;
        cms_pkg::out_t rd;
        case (cms_pkg::op_t'(req.operation))
            cms_pkg::OP_LOAD: begin
                prime_tab[req.row_index]   = (req.row_prime < 31'd2) ? 31'd2 : req.row_prime;
                step_tab[req.row_index]    = req.row_step;
                offset_tab[req.row_index]  = req.row_offset;
                residue_tab[req.row_index] = req.row_offset;
            end
            cms_pkg::OP_SAMPLE: begin
                samples_seen++;
                nrows = (int'(rows_reg) > ROWS) ? ROWS : int'(rows_reg);
                nb    = (buckets_reg == 9'd0) ? 1
                        : ((int'(buckets_reg) > BUCKETS) ? BUCKETS : int'(buckets_reg));
                s     = longint'(req.sample_value);
                for (int r = 0; r < nrows; r++) begin
                    res = (longint'(residue_tab[r]) + longint'(step_tab[r]))
                          % longint'(prime_tab[r]);
                    residue_tab[r] = res[30:0];
                    if (s != 0)
                        add_to_counter(r * nb + int'(res % longint'(nb)), s);
                end
            end
            cms_pkg::OP_READ: begin
                rd.counter_value     = sketch[req.counter_index];
                rd.counter_saturated = sat_flag[req.counter_index];
                read_q.push_back(rd);
            end
            default: begin
                for (int r = 0; r < ROWS; r++)
                    residue_tab[r] = offset_tab[r];
                clear_sketch();
            end
        endcase
    endfunction

    initial begin
        fail_count    = 0;
        reads_checked = 0;
        samples_seen  = 0;
        pending       = 0;
        reset_sketch();
    end

    always @(posedge aclk) begin
        cms_pkg::out_t want;
        if (!aresetn) begin
            reset_sketch();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == cms_pkg::CFG_NUM_ROWS)
                    rows_reg = cfg_wr_data[3:0];
                else
                    buckets_reg = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (read_q.size() == 0) begin
                    $error("unexpected result: counter_value %0d", m_data.counter_value);
                    fail_count++;
                end else begin
                    want = read_q.pop_front();
                    reads_checked++;
                    if (m_data.counter_value !== want.counter_value) begin
                        $error("counter_value: expected %0d, got %0d",
                               want.counter_value, m_data.counter_value);
                        fail_count++;
                    end
                    if (m_data.counter_saturated !== want.counter_saturated) begin
                        $error("counter_saturated: expected %0b, got %0b",
                               want.counter_saturated, m_data.counter_saturated);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                apply_request(s_data);
        end
        pending = read_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Stimulus and verdict for the count-min sketch core.
`timescale 1ns / 100ps
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 2200;   // covers the clearing pass after a start
    localparam int PHASE_ITEMS = 140;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cms_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cms_pkg::out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = cms_pkg::CFG_NUM_ROWS;
    logic [8:0] cfg_wr_data = '0;

    int fail_count, pending, reads_checked, samples_seen;
    int idle_pct  = 34;
    bit hold_req  = 0;
    int cycles    = 0;
    int cur_rows  = 1;
    int cur_bkts  = 256;

    count_min_sketch_accumulate_core DUT (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_wr_en, .cfg_index, .cfg_wr_data
    );

    cms_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .fail_count, .pending, .reads_checked, .samples_seen
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("count_min_sketch_accumulate_core test failed");
            $finish;
        end
    end

    // Result side: random back-pressure plus one long hold on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    function automatic cms_pkg::in_t noise_req();
        cms_pkg::in_t r;
        r.operation     = 2'($urandom);
        r.row_index     = 3'($urandom);
        r.row_prime     = 31'($urandom);
        r.row_step      = 31'($urandom);
        r.row_offset    = 31'($urandom);
        r.sample_value  = $urandom;
        r.counter_index = 11'($urandom);
        return r;
    endfunction

    function automatic cms_pkg::in_t load_req(int row, logic [30:0] p, logic [30:0] a,
                                              logic [30:0] b);
        cms_pkg::in_t r = noise_req();
        r.operation  = cms_pkg::OP_LOAD;
        r.row_index  = 3'(row);
        r.row_prime  = p;
        r.row_step   = a;
        r.row_offset = b;
        return r;
    endfunction

    function automatic cms_pkg::in_t sample_req(logic [31:0] v);
        cms_pkg::in_t r = noise_req();
        r.operation    = cms_pkg::OP_SAMPLE;
        r.sample_value = v;
        return r;
    endfunction

    function automatic cms_pkg::in_t read_req(int idx);
        cms_pkg::in_t r = noise_req();
        r.operation     = cms_pkg::OP_READ;
        r.counter_index = 11'(idx);
        return r;
    endfunction

    function automatic cms_pkg::in_t start_req();
        cms_pkg::in_t r = noise_req();
        r.operation = cms_pkg::OP_START;
        return r;
    endfunction

    function automatic cms_pkg::in_t rand_row_load(int row);
        logic [30:0] p;
        int pick = $urandom_range(0, 9);
        if (pick < 4)
            p = 31'($urandom_range(0, 400));
        else if (pick < 8)
            p = 31'($urandom_range(2, 2000000000));
        else
            p = 31'($urandom);
        if ($urandom_range(0, 3) == 0)
            return load_req(row, p, 31'($urandom), 31'($urandom));
        return load_req(row, p, 31'($urandom_range(0, p < 2 ? 1 : p - 1)),
                        31'($urandom_range(0, p < 2 ? 1 : p - 1)));
    endfunction

    // Mostly samples and reads of live counters, with loads and rare starts.
    function automatic cms_pkg::in_t rand_req();
        int pick = $urandom_range(0, 99);
        int live;
        int nb = (cur_bkts == 0) ? 1 : (cur_bkts > 256 ? 256 : cur_bkts);
        int nr = (cur_rows > 8) ? 8 : cur_rows;
        live = (nr == 0) ? 1 : nr * nb;
        if (pick < 8)
            return rand_row_load($urandom_range(0, 7));
        if (pick < 60) begin
            case ($urandom_range(0, 9))
                0:       return sample_req(32'd0);
                1:       return sample_req($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
                2, 3:    return sample_req(32'($urandom_range(0, 2000) - 1000));
                default: return sample_req($urandom);
            endcase
        end
        if (pick < 99)
            return read_req($urandom_range(0, 4) == 0 ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, live - 1));
        return start_req();
    endfunction

    task automatic send(cms_pkg::in_t req);
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [8:0] val);
        cfg_index   <= idx;
        cfg_wr_data <= val;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    int phase_rows [8] = '{8, 0, 15, 3, 8, 5, 1, 8};
    int phase_bkts [8] = '{256, 7, 300, 1, 0, 97, 256, 511};

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes under the reset configuration (one row, 256 buckets).
        send(load_req(0, 31'd0, 31'h7fffffff, 31'h7fffffff));
        send(sample_req(32'h7fffffff));
        send(sample_req(32'h80000000));
        send(read_req(0));
        send(read_req(1));
        send(load_req(0, 31'd1, 31'd1, 31'd1));
        send(sample_req(32'd0));
        send(sample_req(32'hffffffff));
        send(read_req(0));
        send(read_req(1));
        send(load_req(0, 31'h7fffffff, 31'h7ffffffe, 31'd0));
        send(sample_req(32'd1));
        send(sample_req(32'h00010000));
        send(read_req(254));
        send(read_req(255));
        send(read_req(2047));
        send(load_req(7, 31'd257, 31'd256, 31'd500));
        send(start_req());
        send(sample_req(32'h12345678));
        send(read_req(0));
        send(read_req(1));
        send(read_req(2046));

        foreach (phase_rows[ph]) begin
            drain();
            cur_rows = phase_rows[ph];
            cur_bkts = phase_bkts[ph];
            write_cfg(cms_pkg::CFG_NUM_ROWS, 9'(phase_rows[ph]));
            write_cfg(cms_pkg::CFG_NUM_BUCKETS, 9'(phase_bkts[ph]));
            idle_pct = (ph == 3) ? 0 : 34;
            if (ph == 1)
                hold_req = 1;
            send(start_req());
            for (int r = 0; r < 8; r++)
                send(rand_row_load(r));
            repeat (PHASE_ITEMS) send(rand_req());
        end

        drain();
        $display("covered %0d samples and %0d counter reads over %0d settings of rows/buckets",
                 samples_seen, reads_checked, $size(phase_rows) + 1);
        if (fail_count == 0 && pending == 0)
            $display("count_min_sketch_accumulate_core test passed");
        else
            $display("count_min_sketch_accumulate_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cms_pkg.sv
rtl/cms_mod_cell.sv
rtl/cms_mod_chain.sv
rtl/count_min_sketch_accumulate_core.sv
verif/cms_checker.sv
verif/tb_top.sv
